// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define AST_HOLD(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define AST_IMPLY(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (res)) \
		else $error(msg);

`endif

// ===== rtl/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Types and constants of the text terminal cell buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcb_pkg;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_code;
		logic [3:0] column;
		logic [2:0] row;
	} req_t;

	typedef struct packed {
		logic [2:0] out_row;
		logic [3:0] out_column;
		logic [7:0] out_char;
		logic       whole_line;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [4:0] tab_spacing;
		logic       cursor_enable;
		logic [7:0] cursor_glyph;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] code;
		logic [3:0] column;
		logic [2:0] row;
	} op_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_MOVE   = 2'd1;
	localparam logic [1:0] REQ_FLUSH  = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] CFG_TAB_SPACING   = 2'd0;
	localparam logic [1:0] CFG_CURSOR_ENABLE = 2'd1;
	localparam logic [1:0] CFG_CURSOR_GLYPH  = 2'd2;

	localparam logic [2:0] OP_CHAR  = 3'd0;
	localparam logic [2:0] OP_NL    = 3'd1;
	localparam logic [2:0] OP_TAB   = 3'd2;
	localparam logic [2:0] OP_BS    = 3'd3;
	localparam logic [2:0] OP_IGN   = 3'd4;
	localparam logic [2:0] OP_MOVE  = 3'd5;
	localparam logic [2:0] OP_FLUSH = 3'd6;
	localparam logic [2:0] OP_NOP   = 3'd7;

	localparam logic [7:0] SPACE_CODE = 8'h20;
	localparam logic [7:0] HIGH_LIMIT = 8'h80;
	localparam logic [7:0] NL_CODE    = 8'h0A;
	localparam logic [7:0] TAB_CODE   = 8'h09;
	localparam logic [7:0] BS_CODE    = 8'h08;

	localparam logic [4:0] TAB_RESET   = 5'd4;
	localparam logic [7:0] GLYPH_RESET = 8'h80;

endpackage

`default_nettype wire

// ===== rtl/ttcb_ram.sv =====
// ----------------------------------------------------------------------------
// ttcb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ttcb_front.sv =====
// ----------------------------------------------------------------------------
// ttcb_front
// Accepts request transactions, classifies them and queues them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ttcb_pkg::req_t in_data,
	input  wire logic          hold,
	output logic               op_valid,
	input  wire logic          op_ready,
	output ttcb_pkg::op_t      op
);
	import ttcb_pkg::*;

	op_t        entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	op_t        cls;
	logic [7:0] mapped;
	logic       push;
	logic       pop;

	always_comb begin
		mapped     = (in_data.char_code > HIGH_LIMIT) ? SPACE_CODE : in_data.char_code;
		cls.code   = mapped;
		cls.column = in_data.column;
		cls.row    = in_data.row;
		case (in_data.req_type)
			REQ_PUT: begin
				if (mapped >= SPACE_CODE) begin
					cls.kind = OP_CHAR;
				end else if (mapped == NL_CODE) begin
					cls.kind = OP_NL;
				end else if (mapped == TAB_CODE) begin
					cls.kind = OP_TAB;
				end else if (mapped == BS_CODE) begin
					cls.kind = OP_BS;
				end else begin
					cls.kind = OP_IGN;
				end
			end
			REQ_MOVE:  cls.kind = OP_MOVE;
			REQ_FLUSH: cls.kind = OP_FLUSH;
			default:   cls.kind = OP_NOP;
		endcase
	end

	assign in_ready = (count_q != 2'd2) && !hold;
	assign push     = in_valid && in_ready;
	assign op_valid = (count_q != 2'd0);
	assign pop      = op_valid && op_ready;
	assign op       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ttcb_back.sv =====
// ----------------------------------------------------------------------------
// ttcb_back
// Executes queued operations on the cell RAM, dirty masks and cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcb_back #(
	parameter int NUM_COLUMNS = 16,
	parameter int NUM_ROWS    = 8,
	parameter int CW          = $clog2(NUM_COLUMNS),
	parameter int RW          = $clog2(NUM_ROWS),
	parameter int AW          = CW + RW
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 op_valid,
	output logic                      op_ready,
	input  wire ttcb_pkg::op_t        op,
	input  wire ttcb_pkg::cfg_t       cfg,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ttcb_pkg::res_t            out_data,
	output ttcb_pkg::back_status_t    status,
	output logic                      ram_we,
	output logic [AW-1:0]             ram_waddr,
	output logic [7:0]                ram_wdata,
	output logic [AW-1:0]             ram_raddr,
	input  wire logic [7:0]           ram_rdata
);
	import ttcb_pkg::*;

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_ERASE   = 4'd2;
	localparam logic [3:0] ST_WCHAR   = 4'd3;
	localparam logic [3:0] ST_TAB     = 4'd4;
	localparam logic [3:0] ST_WBS     = 4'd5;
	localparam logic [3:0] ST_FIX     = 4'd6;
	localparam logic [3:0] ST_SCR_RD  = 4'd7;
	localparam logic [3:0] ST_SCR_WR  = 4'd8;
	localparam logic [3:0] ST_SCR_CLR = 4'd9;
	localparam logic [3:0] ST_DRAW    = 4'd10;
	localparam logic [3:0] ST_FL_SCAN = 4'd11;
	localparam logic [3:0] ST_FL_LOAD = 4'd12;

	localparam logic [CW-1:0] LAST_COL = CW'(NUM_COLUMNS - 1);
	localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ROWS - 1);

	logic [3:0]             state_q;
	op_t                    op_q;
	logic [CW-1:0]          cur_col_q;
	logic [RW-1:0]          cur_row_q;
	logic [5:0]             ncol_q;
	logic                   nl_q;
	logic [5:0]             acc_q;
	logic [RW-1:0]          sr_q;
	logic [CW-1:0]          sc_q;
	logic [AW-1:0]          clr_q;
	logic [NUM_COLUMNS-1:0] dirty_q [NUM_ROWS];
	logic [NUM_COLUMNS-1:0] fl_mask_q;
	logic                   fl_whole_q;
	logic [RW-1:0]          fl_row_q;
	logic                   out_valid_q;
	res_t                   out_q;

	logic [5:0]             step;
	logic                   mark;
	logic [RW-1:0]          w_row;
	logic [CW-1:0]          w_col;
	logic                   wrap;
	logic                   fl_ok;
	logic [NUM_COLUMNS-1:0] fl_mask;
	logic [NUM_COLUMNS-1:0] fl_hi;
	logic                   fl_last;

	assign step     = (cfg.tab_spacing == 5'd0) ? 6'd1 : {1'b0, cfg.tab_spacing};
	assign wrap     = ncol_q >= 6'(NUM_COLUMNS);
	assign fl_ok    = int'(op.row) < NUM_ROWS;
	assign fl_mask  = fl_ok ? dirty_q[RW'(op.row)] : '0;
	assign fl_hi    = fl_mask_q >> sc_q;
	assign fl_last  = (fl_hi >> 1) == '0;
	assign op_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign status.clearing = (state_q == ST_CLEAR);
	assign ram_waddr = {w_row, w_col};

	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = SPACE_CODE;
		ram_raddr = {fl_row_q, sc_q};
		mark      = 1'b0;
		w_row     = cur_row_q;
		w_col     = cur_col_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				{w_row, w_col} = clr_q;
			end
			ST_ERASE: begin
				ram_we = cfg.cursor_enable;
				mark   = cfg.cursor_enable;
			end
			ST_WCHAR: begin
				ram_we    = 1'b1;
				mark      = 1'b1;
				ram_wdata = op_q.code;
			end
			ST_WBS: begin
				ram_we = 1'b1;
				mark   = 1'b1;
				w_col  = cur_col_q - 1'b1;
			end
			ST_SCR_RD: begin
				ram_raddr = {RW'(sr_q + 1'b1), sc_q};
			end
			ST_SCR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				w_row     = sr_q;
				w_col     = sc_q;
			end
			ST_SCR_CLR: begin
				ram_we = 1'b1;
				w_row  = LAST_ROW;
				w_col  = sc_q;
			end
			ST_DRAW: begin
				ram_we    = cfg.cursor_enable;
				mark      = cfg.cursor_enable;
				ram_wdata = cfg.cursor_glyph;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && op_valid) begin
			op_q <= op;
		end
		if (state_q == ST_FL_LOAD) begin
			out_q.out_row    <= 3'(fl_row_q);
			out_q.out_column <= 4'(sc_q);
			out_q.out_char   <= ram_rdata;
			out_q.whole_line <= fl_whole_q;
			out_q.last       <= fl_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			ncol_q      <= '0;
			nl_q        <= 1'b0;
			acc_q       <= '0;
			sr_q        <= '0;
			sc_q        <= '0;
			clr_q       <= '0;
			fl_mask_q   <= '0;
			fl_whole_q  <= 1'b0;
			fl_row_q    <= '0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < NUM_ROWS; r++) begin
				dirty_q[r] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (mark) begin
				dirty_q[w_row][w_col] <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					nl_q <= 1'b0;
					if (op_valid) begin
						case (op.kind)
							OP_CHAR: state_q <= ST_WCHAR;
							OP_NL, OP_TAB, OP_MOVE: state_q <= ST_ERASE;
							OP_BS: begin
								if (cur_col_q != '0) begin
									state_q <= ST_ERASE;
								end else begin
									ncol_q  <= 6'(cur_col_q);
									state_q <= ST_FIX;
								end
							end
							OP_IGN: begin
								ncol_q  <= 6'(cur_col_q);
								state_q <= ST_FIX;
							end
							OP_FLUSH: begin
								if (fl_mask != '0) begin
									fl_mask_q  <= fl_mask;
									fl_whole_q <= (fl_mask == '1);
									fl_row_q   <= RW'(op.row);
									dirty_q[RW'(op.row)] <= '0;
									sc_q       <= '0;
									state_q    <= ST_FL_SCAN;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ERASE: begin
					case (op_q.kind)
						OP_NL: begin
							ncol_q  <= '0;
							nl_q    <= 1'b1;
							state_q <= ST_FIX;
						end
						OP_TAB: begin
							acc_q   <= step;
							state_q <= ST_TAB;
						end
						OP_BS: begin
							state_q <= ST_WBS;
						end
						default: begin
							cur_col_q <= (int'(op_q.column) < NUM_COLUMNS) ?
								CW'(op_q.column) : LAST_COL;
							cur_row_q <= (int'(op_q.row) < NUM_ROWS) ?
								RW'(op_q.row) : LAST_ROW;
							state_q   <= ST_DRAW;
						end
					endcase
				end
				ST_WCHAR: begin
					ncol_q  <= 6'(cur_col_q) + 6'd1;
					state_q <= ST_FIX;
				end
				ST_WBS: begin
					ncol_q  <= 6'(cur_col_q) - 6'd1;
					state_q <= ST_FIX;
				end
				ST_TAB: begin
					if (acc_q > 6'(cur_col_q)) begin
						ncol_q  <= acc_q;
						state_q <= ST_FIX;
					end else begin
						acc_q <= acc_q + step;
					end
				end
				ST_FIX: begin
					cur_col_q <= wrap ? '0 : CW'(ncol_q);
					if (nl_q || wrap) begin
						if (cur_row_q == LAST_ROW) begin
							sr_q    <= '0;
							sc_q    <= '0;
							state_q <= ST_SCR_RD;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
							state_q   <= ST_DRAW;
						end
					end else begin
						state_q <= ST_DRAW;
					end
				end
				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end
				ST_SCR_WR: begin
					if (sc_q == LAST_COL) begin
						sc_q <= '0;
						if (sr_q == RW'(NUM_ROWS - 2)) begin
							state_q <= ST_SCR_CLR;
						end else begin
							sr_q    <= sr_q + 1'b1;
							state_q <= ST_SCR_RD;
						end
					end else begin
						sc_q    <= sc_q + 1'b1;
						state_q <= ST_SCR_RD;
					end
				end
				ST_SCR_CLR: begin
					if (sc_q == LAST_COL) begin
						for (int r = 0; r < NUM_ROWS; r++) begin
							dirty_q[r] <= '1;
						end
						state_q <= ST_DRAW;
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				ST_DRAW: begin
					state_q <= ST_IDLE;
				end
				ST_FL_SCAN: begin
					if (fl_hi[0]) begin
						if (!out_valid_q) begin
							state_q <= ST_FL_LOAD;
						end
					end else begin
						sc_q <= sc_q + 1'b1;
					end
				end
				ST_FL_LOAD: begin
					out_valid_q <= 1'b1;
					if (fl_last) begin
						state_q <= ST_IDLE;
					end else begin
						sc_q    <= sc_q + 1'b1;
						state_q <= ST_FL_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/text_terminal_cell_buffer.sv =====
// ----------------------------------------------------------------------------
// text_terminal_cell_buffer
// Character grid terminal with cell RAM, per-row dirty masks and a cursor.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready (put char, move cursor, flush row) and
// pass through a two-entry queue to an execution engine. Redraw transactions
// leave on out_valid/out_ready through an output register; only a flush
// produces them, one per dirty cell, left to right, last set on the final one.
// Configuration is written through cfg_wr_en/cfg_index/cfg_wdata and registered.
// The engine takes one request at a time; a tab steps through each tab stop
// up to the new column, and a scroll copies each row below the top up one row
// and clears the last, through the single RAM read and write port; a flush
// scans column by column and emits one result per dirty cell.
// After reset the engine sweeps the cell RAM to spaces, one entry a cycle, all
// 2**(clog2(NUM_ROWS) + clog2(NUM_COLUMNS)) cells, with in_ready low meanwhile.
// A stalled receiver holds the output register; the flush waits on it and
// the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module text_terminal_cell_buffer #(
	parameter int NUM_COLUMNS = 16,
	parameter int NUM_ROWS    = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire ttcb_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output ttcb_pkg::res_t       out_data,
	input  wire logic            cfg_wr_en,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [7:0]      cfg_wdata
);
	import ttcb_pkg::*;

	localparam int CW = $clog2(NUM_COLUMNS);
	localparam int RW = $clog2(NUM_ROWS);
	localparam int AW = CW + RW;

	cfg_t         cfg_q;
	op_t          op;
	logic         op_valid;
	logic         op_ready;
	back_status_t status;
	logic         ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]   ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]   ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tab_spacing   <= TAB_RESET;
			cfg_q.cursor_enable <= 1'b0;
			cfg_q.cursor_glyph  <= GLYPH_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TAB_SPACING:   cfg_q.tab_spacing   <= cfg_wdata[4:0];
				CFG_CURSOR_ENABLE: cfg_q.cursor_enable <= cfg_wdata[0];
				CFG_CURSOR_GLYPH:  cfg_q.cursor_glyph  <= cfg_wdata;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	ttcb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.hold     (status.clearing),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	ttcb_back #(
		.NUM_COLUMNS (NUM_COLUMNS),
		.NUM_ROWS    (NUM_ROWS),
		.CW          (CW),
		.RW          (RW),
		.AW          (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_ready  (op_ready),
		.op        (op),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.status    (status),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	ttcb_ram #(
		.WIDTH (8),
		.DEPTH (1 << AW)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	`AST_IMPLY(a_clear_blocks_input, status.clearing, !in_ready, "input taken during RAM clear")
	`AST_IMPLY(a_out_col_in_grid, out_valid, int'(out_data.out_column) < NUM_COLUMNS, "column off grid")
	`AST_IMPLY(a_out_row_in_grid, out_valid, int'(out_data.out_row) < NUM_ROWS, "row off grid")

endmodule

`default_nettype wire
